>>> src/plb_pkg.sv
// ----------------------------------------------------------------------------
// plb_pkg
// Shared types and constants of the positional list buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package plb_pkg;

  localparam int CAPACITY_DEF = 32;

  localparam int VALUE_W = 32;
  localparam int POS_W   = 8;
  localparam int COUNT_W = 6;
  localparam int STAT_W  = 2;
  // wide enough to compare a position against size + 1 for capacities up to 510
  localparam int CMP_W   = 9;

  typedef enum logic [2:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_BACK  = 3'd1,
    OP_INS_POS   = 3'd2,
    OP_DEL_FRONT = 3'd3,
    OP_DEL_BACK  = 3'd4,
    OP_DEL_POS   = 3'd5,
    OP_LIST      = 3'd6,
    OP_COUNT     = 3'd7
  } opcode_t;

  localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STAT_W-1:0] ST_IGNORED = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;

  // classified command handed from the front to the back
  typedef struct packed {
    logic                      ins;
    logic                      del;
    logic                      lst;
    logic                      at_front;
    logic                      at_back;
    logic signed [VALUE_W-1:0] value;
    logic [POS_W-1:0]          position;
  } cmd_t;

endpackage

`default_nettype wire

>>> src/plb_front.sv
// ----------------------------------------------------------------------------
// plb_front
// Accepts input items and classifies the opcode into a command.
// ----------------------------------------------------------------------------
`default_nettype none

module plb_front (
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [2:0]                    in_opcode,
  input  wire logic signed [31:0]            in_value,
  input  wire logic [7:0]                    in_position,
  input  wire logic                          q_full,
  output logic                               q_push,
  output plb_pkg::cmd_t                      q_cmd
);
  import plb_pkg::*;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_cmd          = '0;
    q_cmd.value    = in_value;
    q_cmd.position = in_position;
    unique case (opcode_t'(in_opcode))
      OP_INS_FRONT: begin
        q_cmd.ins      = 1'b1;
        q_cmd.at_front = 1'b1;
      end
      OP_INS_BACK: begin
        q_cmd.ins     = 1'b1;
        q_cmd.at_back = 1'b1;
      end
      OP_INS_POS: begin
        q_cmd.ins = 1'b1;
      end
      OP_DEL_FRONT: begin
        q_cmd.del      = 1'b1;
        q_cmd.at_front = 1'b1;
      end
      OP_DEL_BACK: begin
        q_cmd.del     = 1'b1;
        q_cmd.at_back = 1'b1;
      end
      OP_DEL_POS: begin
        q_cmd.del = 1'b1;
      end
      OP_LIST: begin
        q_cmd.lst = 1'b1;
      end
      default: begin
        // count: no flags set
      end
    endcase
  end

endmodule

`default_nettype wire

>>> src/plb_queue.sv
// ----------------------------------------------------------------------------
// plb_queue
// Two-entry command queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module plb_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire plb_pkg::cmd_t push_cmd,
  output logic               full,
  output logic               head_valid,
  output plb_pkg::cmd_t      head_cmd,
  input  wire logic          pop
);
  import plb_pkg::*;

  cmd_t       slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] fill_r, fill_nxt;
  logic       do_pop;

  assign full       = (fill_r == 2'd2);
  assign head_valid = (fill_r != 2'd0);
  assign head_cmd   = slot_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = push   ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    fill_nxt   = fill_r + 2'(push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

>>> src/plb_back.sv
// ----------------------------------------------------------------------------
// plb_back
// Shifting cell row, list sequencer and registered result stage.
// ----------------------------------------------------------------------------
`default_nettype none

module plb_back #(
  parameter int CAPACITY = plb_pkg::CAPACITY_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cmd_valid,
  input  wire plb_pkg::cmd_t      cmd,
  output logic                    cmd_pop,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [1:0]              out_status,
  output logic signed [31:0]      out_item_value,
  output logic [5:0]              out_entry_count,
  output logic                    out_last
);
  import plb_pkg::*;

  localparam int SZW = $clog2(CAPACITY + 1);
  localparam int IW  = $clog2(CAPACITY);

  typedef enum logic [1:0] {
    BK_IDLE = 2'b01,
    BK_LIST = 2'b10
  } bk_state_t;

  bk_state_t                 state_r, state_nxt;
  logic [SZW-1:0]            size_r, size_nxt;
  logic [SZW-1:0]            cnt_r, cnt_nxt;
  logic signed [VALUE_W-1:0] cells_r [CAPACITY];
  logic signed [VALUE_W-1:0] cells_nxt [CAPACITY];

  logic                      slot_free;
  logic                      emit;
  logic [STAT_W-1:0]         res_status;
  logic signed [VALUE_W-1:0] res_value;
  logic                      res_last;
  logic                      do_ins, do_del, do_rot;
  logic [IW-1:0]             idx;
  logic [CMP_W-1:0]          pos_w, size_w;
  logic                      full, empty;

  logic                      out_valid_r;
  logic [STAT_W-1:0]         out_status_r;
  logic signed [VALUE_W-1:0] out_value_r;
  logic [COUNT_W-1:0]        out_count_r;
  logic                      out_last_r;

  assign slot_free = !out_valid_r || out_ready;
  assign pos_w     = CMP_W'(cmd.position);
  assign size_w    = CMP_W'(size_r);
  assign full      = (size_r == SZW'(CAPACITY));
  assign empty     = (size_r == '0);

  // control and sequencing
  always_comb begin
    state_nxt  = state_r;
    size_nxt   = size_r;
    cnt_nxt    = cnt_r;
    cmd_pop    = 1'b0;
    emit       = 1'b0;
    res_status = ST_DONE;
    res_value  = '0;
    res_last   = 1'b1;
    do_ins     = 1'b0;
    do_del     = 1'b0;
    do_rot     = 1'b0;
    idx        = '0;
    unique case (state_r)
      BK_IDLE: begin
        if (cmd_valid && slot_free) begin
          cmd_pop = 1'b1;
          emit    = 1'b1;
          if (cmd.lst) begin
            if (empty) begin
              res_status = ST_IGNORED;
            end else begin
              // the command stays at the queue head until the last entry
              cmd_pop   = 1'b0;
              emit      = 1'b0;
              state_nxt = BK_LIST;
              cnt_nxt   = '0;
            end
          end else if (cmd.ins) begin
            if (full) begin
              res_status = ST_FULL;
            end else if (cmd.at_front) begin
              do_ins = 1'b1;
              idx    = '0;
            end else if (cmd.at_back) begin
              do_ins = 1'b1;
              idx    = IW'(size_r);
            end else if (pos_w == '0 || pos_w > size_w + CMP_W'(1)) begin
              res_status = ST_IGNORED;
            end else begin
              do_ins = 1'b1;
              idx    = IW'(pos_w - CMP_W'(1));
            end
            if (do_ins) begin
              size_nxt = size_r + SZW'(1);
            end
          end else if (cmd.del) begin
            if (empty) begin
              res_status = ST_IGNORED;
            end else if (cmd.at_front) begin
              do_del = 1'b1;
              idx    = '0;
            end else if (cmd.at_back) begin
              do_del = 1'b1;
              idx    = IW'(size_r - SZW'(1));
            end else if (pos_w == '0 || pos_w > size_w) begin
              res_status = ST_IGNORED;
            end else begin
              do_del = 1'b1;
              idx    = IW'(pos_w - CMP_W'(1));
            end
            if (do_del) begin
              size_nxt = size_r - SZW'(1);
            end
          end
        end
      end
      BK_LIST: begin
        if (slot_free) begin
          emit      = 1'b1;
          do_rot    = 1'b1;
          res_value = cells_r[0];
          res_last  = (SZW'(cnt_r + SZW'(1)) == size_r);
          cnt_nxt   = cnt_r + SZW'(1);
          if (res_last) begin
            cmd_pop   = 1'b1;
            state_nxt = BK_IDLE;
          end
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  // cell row: insert shifts up, delete shifts down, listing rotates the
  // occupied cells so the front entry is always read from cell 0
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cells_nxt[i] = cells_r[i];
    end
    if (do_ins) begin
      if (idx == '0) begin
        cells_nxt[0] = cmd.value;
      end
      for (int i = 1; i < CAPACITY; i++) begin
        if (IW'(i) > idx) begin
          cells_nxt[i] = cells_r[i-1];
        end else if (IW'(i) == idx) begin
          cells_nxt[i] = cmd.value;
        end
      end
    end else if (do_del) begin
      for (int i = 0; i < CAPACITY - 1; i++) begin
        if (IW'(i) >= idx) begin
          cells_nxt[i] = cells_r[i+1];
        end
      end
    end else if (do_rot) begin
      for (int i = 0; i < CAPACITY - 1; i++) begin
        if (SZW'(i + 1) == size_r) begin
          cells_nxt[i] = cells_r[0];
        end else if (SZW'(i + 1) < size_r) begin
          cells_nxt[i] = cells_r[i+1];
        end
      end
      if (full) begin
        cells_nxt[CAPACITY-1] = cells_r[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      size_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      size_r  <= size_nxt;
      cnt_r   <= cnt_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < CAPACITY; i++) begin
      cells_r[i] <= cells_nxt[i];
    end
    if (emit) begin
      out_status_r <= res_status;
      out_value_r  <= res_value;
      out_count_r  <= COUNT_W'(size_nxt);
      out_last_r   <= res_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_item_value  = out_value_r;
  assign out_entry_count = out_count_r;
  assign out_last        = out_last_r;

  a_size_bound : assert property (@(posedge clk) disable iff (!rst_n)
    size_r <= SZW'(CAPACITY))
    else $error("entry count above capacity");

  a_list_nonempty : assert property (@(posedge clk) disable iff (!rst_n)
    state_r == BK_LIST |-> (size_r != '0) && (cnt_r < size_r))
    else $error("list walk outside occupied cells");

  a_size_step : assert property (@(posedge clk) disable iff (!rst_n)
    ##1 (size_r == $past(size_r) || size_r == $past(size_r) + SZW'(1) ||
         size_r == $past(size_r) - SZW'(1)))
    else $error("entry count moved by more than one");

  a_list_holds_size : assert property (@(posedge clk) disable iff (!rst_n)
    state_r == BK_LIST |=> size_r == $past(size_r))
    else $error("entry count changed during list walk");

endmodule

`default_nettype wire

>>> src/positional_list_buffer.sv
// ----------------------------------------------------------------------------
// positional_list_buffer
// Bounded ordered list of signed 32-bit values with positional insert and
// delete, listing and count.
// ----------------------------------------------------------------------------
// Usage: items enter on the in_ channel (opcode, value, position) with
// valid/ready and results leave on the out_ channel with valid/ready.
// The front decodes each item into a two-entry queue; the back keeps the
// entries in a row of shifting cells and owns a registered result stage.
// An accepted item is queued, taken by the back from the queue head, and
// its result registered in the result stage. Every opcode but listing is
// handled in the idle state, so one item per cycle is sustained while the
// receiver is ready. A listing first enters the list state without a
// result, then emits one result per entry; the cell row rotates once per
// entry so each value is read from the front cell. Only listing emits
// more than one result; the final result of every item has out_last set.
// When the receiver stalls the result register holds, the back stops, and
// the queue absorbs up to two more items before in_ready drops. Reset
// clears the entry count, the queue and the result valid flag; cell
// contents are not cleared and are never read unless occupied.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_list_buffer #(
  parameter int CAPACITY = plb_pkg::CAPACITY_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [2:0]         in_opcode,
  input  wire logic signed [31:0] in_value,
  input  wire logic [7:0]         in_position,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [1:0]              out_status,
  output logic signed [31:0]      out_item_value,
  output logic [5:0]              out_entry_count,
  output logic                    out_last
);
  import plb_pkg::*;

  logic q_full;
  logic q_push;
  cmd_t q_cmd;
  logic head_valid;
  cmd_t head_cmd;
  logic cmd_pop;

  plb_front u_front (
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_opcode   (in_opcode),
    .in_value    (in_value),
    .in_position (in_position),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_cmd       (q_cmd)
  );

  plb_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (q_cmd),
    .full       (q_full),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (cmd_pop)
  );

  plb_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_valid       (head_valid),
    .cmd             (head_cmd),
    .cmd_pop         (cmd_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_item_value  (out_item_value),
    .out_entry_count (out_entry_count),
    .out_last        (out_last)
  );

endmodule

`default_nettype wire
